// ===== hw/rtl/obpc_pkg.sv =====
// Shared types and constants for the oriented box point classifier.
package obpc_pkg;

  localparam int LANE_W    = 16;
  localparam int NUM_AXES  = 3;
  localparam int FRAC_BITS = 14;
  localparam int CFG_W     = 64;
  localparam int ADDR_W    = 6;
  localparam int IDX_LSB   = 3;
  localparam int REG_W     = 48;
  localparam int DIST_W    = 18;
  localparam int AXIS_W    = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic signed [LANE_W-1:0] lane_t;
  typedef logic [REG_W-1:0]         reg48_t;
  typedef logic [DIST_W-1:0]        dist_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [ADDR_W-IDX_LSB-1:0] {
    REG_ROT0   = 3'd0,
    REG_ROT1   = 3'd1,
    REG_ROT2   = 3'd2,
    REG_CENTER = 3'd3,
    REG_HALF   = 3'd4,
    REG_THRESH = 3'd5
  } reg_idx_t;

  localparam reg48_t ROT0_RESET = 48'h0000_0000_4000;
  localparam reg48_t ROT1_RESET = 48'h0000_4000_0000;
  localparam reg48_t ROT2_RESET = 48'h4000_0000_0000;

  function automatic lane_t lane_of(input reg48_t r, input int k);
    lane_of = r[k*LANE_W +: LANE_W];
  endfunction

endpackage

// ===== hw/rtl/obpc_if.sv =====
// Item channel interfaces for points in and classification results out.
interface obpc_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface obpc_out_if ();
  import obpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              inside_res;
  logic              near_face;
  dist_t             side_distance;
  logic [AXIS_W-1:0] nearest_axis;

  modport source (output valid, output inside_res, output near_face, output side_distance,
                  output nearest_axis, input ready);
  modport sink   (input valid, input inside_res, input near_face, input side_distance,
                  input nearest_axis, output ready);
endinterface

// ===== hw/rtl/oriented_box_point_classifier_top.sv =====
// Oriented box point classifier: config registers and four-stage classification pipeline.
// The input register takes the item at acceptance; the later stages then do subtract and multiply,
// row sum and magnitude, and face compare and rounding.
// Throughput: one item per cycle; the whole pipeline stalls only while a result is not taken.
// Reset: synchronous active-low rst_n empties the pipeline and loads the identity rotation,
// zero centre, zero half extents and zero threshold.
module oriented_box_point_classifier_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  obpc_in_if.sink                  in_ch,
  obpc_out_if.source               out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [obpc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [obpc_pkg::CFG_W-1:0]  cfg_pwdata,
  output logic [obpc_pkg::CFG_W-1:0]  cfg_prdata,
  output logic                     cfg_pready
);
  import obpc_pkg::*;

  localparam int DW = ((COORD_WIDTH > LANE_W) ? COORD_WIDTH : LANE_W) + 1;
  localparam int PW = DW + LANE_W;
  localparam int QW = PW + 2;
  localparam int AW = (QW > FRAC_BITS + DIST_W + 1) ? QW : FRAC_BITS + DIST_W + 1;

  reg48_t             rot_r [NUM_AXES];
  reg48_t             center_r;
  reg48_t             half_r;
  logic [LANE_W-1:0]  thr_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROT0_RESET;
      rot_r[1] <= ROT1_RESET;
      rot_r[2] <= ROT2_RESET;
      center_r <= '0;
      half_r   <= '0;
      thr_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[ADDR_W-1:IDX_LSB])
        REG_ROT0:   rot_r[0] <= cfg_pwdata[REG_W-1:0];
        REG_ROT1:   rot_r[1] <= cfg_pwdata[REG_W-1:0];
        REG_ROT2:   rot_r[2] <= cfg_pwdata[REG_W-1:0];
        REG_CENTER: center_r <= cfg_pwdata[REG_W-1:0];
        REG_HALF:   half_r   <= cfg_pwdata[REG_W-1:0];
        REG_THRESH: thr_r    <= cfg_pwdata[LANE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[ADDR_W-1:IDX_LSB])
      REG_ROT0:   cfg_prdata = CFG_W'(rot_r[0]);
      REG_ROT1:   cfg_prdata = CFG_W'(rot_r[1]);
      REG_ROT2:   cfg_prdata = CFG_W'(rot_r[2]);
      REG_CENTER: cfg_prdata = CFG_W'(center_r);
      REG_HALF:   cfg_prdata = CFG_W'(half_r);
      REG_THRESH: cfg_prdata = CFG_W'(thr_r);
      default:    cfg_prdata = '0;
    endcase
  end

  logic pipe_en;
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;

  assign pipe_en     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  logic signed [COORD_WIDTH-1:0] pt_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pt_r[0] <= in_ch.point_x;
      pt_r[1] <= in_ch.point_y;
      pt_r[2] <= in_ch.point_z;
    end
  end

  logic signed [DW-1:0] diff_nxt [NUM_AXES];
  logic signed [PW-1:0] prod_r   [NUM_AXES][NUM_AXES];

  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      diff_nxt[j] = DW'(pt_r[j]) - DW'(lane_of(center_r, j));
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          prod_r[i][j] <= PW'(lane_of(rot_r[i], j)) * PW'(diff_nxt[j]);
        end
      end
    end
  end

  logic signed [QW-1:0] q_nxt   [NUM_AXES];
  logic        [QW-1:0] qneg_nxt[NUM_AXES];
  logic        [AW-1:0] mag_r   [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      q_nxt[i]    = QW'(prod_r[i][0]) + QW'(prod_r[i][1]) + QW'(prod_r[i][2]);
      qneg_nxt[i] = QW'(-q_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        mag_r[i] <= AW'(q_nxt[i][QW-1] ? qneg_nxt[i] : q_nxt[i]);
      end
    end
  end

  logic [AW-1:0] hq     [NUM_AXES];
  logic [AW-1:0] dist_q [NUM_AXES];
  logic          in_ax  [NUM_AXES];
  logic [AW-1:0] best;
  axis_t         best_axis;
  logic [AW:0]   rnd;
  logic          inside_nxt, near_nxt;
  dist_t         dist_nxt;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      hq[i]     = AW'(half_r[i*LANE_W +: LANE_W]) << FRAC_BITS;
      in_ax[i]  = mag_r[i] < hq[i];
      dist_q[i] = in_ax[i] ? (hq[i] - mag_r[i]) : (mag_r[i] - hq[i]);
    end
    best      = dist_q[0];
    best_axis = AXIS_X;
    if (dist_q[1] < best) begin
      best      = dist_q[1];
      best_axis = AXIS_Y;
    end
    if (dist_q[2] < best) begin
      best      = dist_q[2];
      best_axis = AXIS_Z;
    end
    inside_nxt = in_ax[0] && in_ax[1] && in_ax[2];
    near_nxt   = best < (AW'(thr_r) << FRAC_BITS);
    rnd        = (AW+1)'(best) + ((AW+1)'(1) << (FRAC_BITS - 1));
    dist_nxt   = (|rnd[AW:FRAC_BITS+DIST_W]) ? DIST_MAX : rnd[FRAC_BITS +: DIST_W];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_ch.inside_res    <= inside_nxt;
      out_ch.near_face     <= near_nxt;
      out_ch.side_distance <= dist_nxt;
      out_ch.nearest_axis  <= best_axis;
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef SYNTHESIS
  a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.nearest_axis <= AXIS_Z))
    else $error("nearest axis code out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_valid_r)
    else $error("accepted item missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> ($stable(s2_valid_r) && $stable(s3_valid_r) && $stable(mag_r[0])))
    else $error("pipeline advanced during stall");
`endif

endmodule
